>>> hw/rtl/dsu_pkg.sv
// ----------------------------------------------------------------------------
// dsu_pkg
// Shared types and constants of the disjoint-set union engine.
// ----------------------------------------------------------------------------
`default_nettype none

package dsu_pkg;

    localparam int unsigned IDX_W  = 10;
    localparam int unsigned CNT_W  = 11;
    localparam int unsigned EDGE_W = 32;
    localparam logic [EDGE_W-1:0] EDGE_MAX = '1;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_UNITE = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CHECK,
        ST_FA_RD,
        ST_FA_WAIT,
        ST_FA_TEST,
        ST_CA_RD,
        ST_CA_WAIT,
        ST_CA_WR,
        ST_FB_RD,
        ST_FB_WAIT,
        ST_FB_TEST,
        ST_CB_RD,
        ST_CB_WAIT,
        ST_CB_WR,
        ST_RA_RD,
        ST_RA_WAIT,
        ST_RB_WAIT,
        ST_MERGE,
        ST_RES_RD,
        ST_RES_WAIT,
        ST_OUT
    } state_t;

    // Datapath commands from the controller.
    typedef struct packed {
        logic cfg_load;
        logic clr_start;
        logic clr_step;
        logic item_load;
        logic cur_from_a;
        logic cur_from_b;
        logic cur_from_comp;
        logic rd_parent_cur;
        logic follow_link;
        logic save_root_a;
        logic save_root_b;
        logic wr_compress;
        logic rd_root_a;
        logic rd_root_b;
        logic cap_root_a;
        logic cap_root_b;
        logic do_merge;
        logic rd_result;
        logic cap_result;
        logic set_bad;
    } dp_cmd_t;

    // Datapath status back to the controller.
    typedef struct packed {
        logic clr_done;
        logic bad;
        logic at_root;
        logic comp_done;
        logic is_unite;
    } dp_sts_t;

endpackage : dsu_pkg

`default_nettype wire

>>> hw/rtl/dsu_ram.sv
// ----------------------------------------------------------------------------
// dsu_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dsu_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule : dsu_ram

`default_nettype wire

>>> hw/rtl/dsu_datapath.sv
// ----------------------------------------------------------------------------
// dsu_datapath
// Node memories, root-search pointer and merge arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module dsu_datapath #(
    parameter int unsigned NODES = 1024
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire dsu_pkg::dp_cmd_t           cmd,
    output dsu_pkg::dp_sts_t                sts,
    input  wire logic [dsu_pkg::CNT_W-1:0]  cfg_value,
    input  wire logic                       in_op,
    input  wire logic [dsu_pkg::IDX_W-1:0]  in_a,
    input  wire logic [dsu_pkg::IDX_W-1:0]  in_b,
    output logic [dsu_pkg::IDX_W-1:0]       res_root_a,
    output logic [dsu_pkg::IDX_W-1:0]       res_root_b,
    output logic                            res_joined,
    output logic                            res_merged,
    output logic [dsu_pkg::CNT_W-1:0]       res_members,
    output logic [dsu_pkg::EDGE_W-1:0]      res_edges,
    output logic [dsu_pkg::CNT_W-1:0]       res_groups,
    output logic                            res_bad
);

    localparam int unsigned AW = $clog2(NODES);
    localparam int unsigned MW = $clog2(NODES + 1);
    localparam logic [MW-1:0] NODES_M = MW'(NODES);

    logic [MW-1:0]    elem_reg;
    logic [MW-1:0]    groups_reg;
    logic [AW:0]      clr_reg;
    logic             op_reg;
    logic [AW-1:0]    a_reg, b_reg, cur_reg, root_a_reg, root_b_reg, next_reg;
    logic [MW-1:0]    mem_a_reg, mem_b_reg;
    logic [31:0]      edge_a_reg, edge_b_reg;
    logic             joined_reg, merged_reg;
    logic [dsu_pkg::IDX_W-1:0] op_a_full, op_b_full;
    logic             clearing;

    logic             p_we, s_we, e_we;
    logic [AW-1:0]    p_addr, s_addr;
    logic [AW-1:0]    p_wdata;
    logic [MW-1:0]    s_wdata;
    logic [31:0]      e_wdata;
    logic [AW-1:0]    p_rdata;
    logic [MW-1:0]    s_rdata;
    logic [31:0]      e_rdata;

    logic             a_wins;
    logic [AW-1:0]    win, lose;
    logic [31:0]      ea_inc, e_sum;
    logic [32:0]      sum_w;
    logic [MW-1:0]    cfg_clamped;

    dsu_ram #(.WIDTH(AW), .DEPTH(NODES)) u_parent (
        .aclk(aclk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata)
    );
    dsu_ram #(.WIDTH(MW), .DEPTH(NODES)) u_size (
        .aclk(aclk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
    );
    dsu_ram #(.WIDTH(32), .DEPTH(NODES)) u_edge (
        .aclk(aclk), .we(e_we), .addr(s_addr), .wdata(e_wdata), .rdata(e_rdata)
    );

    assign clearing = cmd.clr_step;
    assign ea_inc   = (edge_a_reg == dsu_pkg::EDGE_MAX) ? edge_a_reg : edge_a_reg + 32'd1;
    assign a_wins   = !(mem_a_reg < mem_b_reg);
    assign win      = a_wins ? root_a_reg : root_b_reg;
    assign lose     = a_wins ? root_b_reg : root_a_reg;
    assign sum_w    = {1'b0, ea_inc} + {1'b0, edge_b_reg};
    assign e_sum    = sum_w[32] ? dsu_pkg::EDGE_MAX : sum_w[31:0];

    always_comb begin
        if (cfg_value == '0) begin
            cfg_clamped = MW'(1);
        end else if (32'(cfg_value) > 32'(NODES)) begin
            cfg_clamped = NODES_M;
        end else begin
            cfg_clamped = MW'(cfg_value);
        end
    end

    always_comb begin
        p_we = 1'b0; s_we = 1'b0; e_we = 1'b0;
        p_addr = cur_reg; s_addr = cur_reg;
        p_wdata = cur_reg; s_wdata = MW'(1); e_wdata = '0;
        if (clearing) begin
            p_we = 1'b1; s_we = 1'b1; e_we = 1'b1;
            p_addr = clr_reg[AW-1:0]; s_addr = clr_reg[AW-1:0];
            p_wdata = clr_reg[AW-1:0];
        end else if (cmd.wr_compress) begin
            p_we = 1'b1;
            p_wdata = next_reg;
        end else if (cmd.rd_root_a) begin
            s_addr = root_a_reg;
        end else if (cmd.rd_root_b) begin
            s_addr = root_b_reg;
        end else if (cmd.do_merge) begin
            s_addr = win;
            if (op_reg == dsu_pkg::OP_UNITE) begin
                e_we = 1'b1;
                if (root_a_reg == root_b_reg) begin
                    s_addr = root_a_reg;
                    e_wdata = ea_inc;
                end else begin
                    s_we = 1'b1;
                    s_wdata = mem_a_reg + mem_b_reg;
                    e_wdata = e_sum;
                    p_we = 1'b1;
                    p_addr = lose;
                    p_wdata = win;
                end
            end
        end else if (cmd.rd_result) begin
            s_addr = root_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_reg   <= (NODES < 1024) ? NODES_M : MW'(1024);
            groups_reg <= (NODES < 1024) ? NODES_M : MW'(1024);
            clr_reg    <= '0;
        end else begin
            if (cmd.cfg_load) begin
                elem_reg   <= cfg_clamped;
                groups_reg <= cfg_clamped;
            end
            if (cmd.clr_start) begin
                clr_reg <= '0;
            end else if (clearing) begin
                clr_reg <= clr_reg + (AW+1)'(1);
            end
            if (cmd.do_merge && op_reg == dsu_pkg::OP_UNITE && root_a_reg != root_b_reg
                    && groups_reg > MW'(1)) begin
                groups_reg <= groups_reg - MW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            op_reg    <= in_op;
            a_reg     <= AW'(in_a);
            b_reg     <= AW'(in_b);
            op_a_full <= in_a;
            op_b_full <= in_b;
        end
        if (cmd.cur_from_a) begin
            cur_reg <= a_reg;
        end else if (cmd.cur_from_b) begin
            cur_reg <= b_reg;
        end else if (cmd.follow_link) begin
            cur_reg <= p_rdata;
        end else if (cmd.cur_from_comp) begin
            cur_reg <= p_rdata;
        end
        if (cmd.save_root_a) begin
            root_a_reg <= cur_reg;
        end
        if (cmd.save_root_b) begin
            root_b_reg <= cur_reg;
        end
        if (cmd.cap_root_a) begin
            mem_a_reg  <= s_rdata;
            edge_a_reg <= e_rdata;
        end
        if (cmd.cap_root_b) begin
            mem_b_reg  <= s_rdata;
            edge_b_reg <= e_rdata;
        end
        if (cmd.save_root_a || cmd.save_root_b) begin
            next_reg <= cur_reg;
        end
        if (cmd.do_merge) begin
            joined_reg <= (root_a_reg == root_b_reg);
            merged_reg <= (op_reg == dsu_pkg::OP_UNITE) && (root_a_reg != root_b_reg);
            if (op_reg == dsu_pkg::OP_UNITE) begin
                root_a_reg <= win;
                root_b_reg <= win;
            end
        end
        if (cmd.cap_result) begin
            res_root_a  <= dsu_pkg::IDX_W'(root_a_reg);
            res_root_b  <= dsu_pkg::IDX_W'(root_b_reg);
            res_joined  <= joined_reg;
            res_merged  <= merged_reg;
            res_members <= dsu_pkg::CNT_W'(s_rdata);
            res_edges   <= e_rdata;
            res_groups  <= dsu_pkg::CNT_W'(groups_reg);
            res_bad     <= 1'b0;
        end
        if (cmd.set_bad) begin
            res_root_a  <= '0;
            res_root_b  <= '0;
            res_joined  <= 1'b0;
            res_merged  <= 1'b0;
            res_members <= '0;
            res_edges   <= '0;
            res_groups  <= dsu_pkg::CNT_W'(groups_reg);
            res_bad     <= 1'b1;
        end
    end

    always_comb begin
        sts.clr_done  = (clr_reg == (AW+1)'(NODES - 1));
        sts.bad       = (MW'(a_reg) >= elem_reg)
                     || (MW'(b_reg) >= elem_reg)
                     || (a_reg != AW'(op_a_full)) || (b_reg != AW'(op_b_full));
        sts.at_root   = (p_rdata == cur_reg);
        sts.comp_done = (cur_reg == next_reg);
        sts.is_unite  = (op_reg == dsu_pkg::OP_UNITE);
    end

endmodule : dsu_datapath

`default_nettype wire

>>> hw/rtl/dsu_ctrl.sv
// ----------------------------------------------------------------------------
// dsu_ctrl
// Sequencer for clear, root searches with path compression and merge.
// ----------------------------------------------------------------------------
`default_nettype none

module dsu_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output dsu_pkg::dp_cmd_t       cmd,
    input  wire dsu_pkg::dp_sts_t  sts
);

    dsu_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    assign m_tvalid  = out_valid_reg;
    assign cfg_ready = (state_reg == dsu_pkg::ST_IDLE) && !out_valid_reg;
    assign s_tready  = (state_reg == dsu_pkg::ST_IDLE) && !cfg_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dsu_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        case (state_reg)
            dsu_pkg::ST_IDLE: begin
                if (cfg_valid && cfg_ready) begin
                    cmd.cfg_load  = 1'b1;
                    cmd.clr_start = 1'b1;
                    state_next    = dsu_pkg::ST_CLEAR;
                end else if (s_tvalid && s_tready) begin
                    cmd.item_load = 1'b1;
                    state_next    = dsu_pkg::ST_CHECK;
                end
            end
            dsu_pkg::ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done) begin
                    state_next = dsu_pkg::ST_IDLE;
                end
            end
            dsu_pkg::ST_CHECK: begin
                if (sts.bad) begin
                    if (!out_valid_reg || m_tready) begin
                        cmd.set_bad    = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = dsu_pkg::ST_IDLE;
                    end
                end else begin
                    cmd.cur_from_a = 1'b1;
                    state_next     = dsu_pkg::ST_FA_RD;
                end
            end
            dsu_pkg::ST_FA_RD:   state_next = dsu_pkg::ST_FA_WAIT;
            dsu_pkg::ST_FA_WAIT: state_next = dsu_pkg::ST_FA_TEST;
            dsu_pkg::ST_FA_TEST: begin
                if (sts.at_root) begin
                    cmd.save_root_a = 1'b1;
                    cmd.cur_from_a  = 1'b1;
                    state_next      = dsu_pkg::ST_CA_RD;
                end else begin
                    cmd.follow_link = 1'b1;
                    state_next      = dsu_pkg::ST_FA_RD;
                end
            end
            dsu_pkg::ST_CA_RD: begin
                if (sts.comp_done) begin
                    cmd.cur_from_b = 1'b1;
                    state_next     = dsu_pkg::ST_FB_RD;
                end else begin
                    state_next = dsu_pkg::ST_CA_WAIT;
                end
            end
            dsu_pkg::ST_CA_WAIT: state_next = dsu_pkg::ST_CA_WR;
            dsu_pkg::ST_CA_WR: begin
                cmd.cur_from_comp = 1'b1;
                cmd.wr_compress   = 1'b1;
                state_next        = dsu_pkg::ST_CA_RD;
            end
            dsu_pkg::ST_FB_RD:   state_next = dsu_pkg::ST_FB_WAIT;
            dsu_pkg::ST_FB_WAIT: state_next = dsu_pkg::ST_FB_TEST;
            dsu_pkg::ST_FB_TEST: begin
                if (sts.at_root) begin
                    cmd.save_root_b = 1'b1;
                    cmd.cur_from_b  = 1'b1;
                    state_next      = dsu_pkg::ST_CB_RD;
                end else begin
                    cmd.follow_link = 1'b1;
                    state_next      = dsu_pkg::ST_FB_RD;
                end
            end
            dsu_pkg::ST_CB_RD: begin
                if (sts.comp_done) begin
                    state_next = dsu_pkg::ST_RA_RD;
                end else begin
                    state_next = dsu_pkg::ST_CB_WAIT;
                end
            end
            dsu_pkg::ST_CB_WAIT: state_next = dsu_pkg::ST_CB_WR;
            dsu_pkg::ST_CB_WR: begin
                cmd.cur_from_comp = 1'b1;
                cmd.wr_compress   = 1'b1;
                state_next        = dsu_pkg::ST_CB_RD;
            end
            dsu_pkg::ST_RA_RD: begin
                cmd.rd_root_a = 1'b1;
                state_next    = dsu_pkg::ST_RA_WAIT;
            end
            dsu_pkg::ST_RA_WAIT: begin
                cmd.cap_root_a = 1'b1;
                cmd.rd_root_b  = 1'b1;
                state_next     = dsu_pkg::ST_RB_WAIT;
            end
            dsu_pkg::ST_RB_WAIT: begin
                cmd.cap_root_b = 1'b1;
                state_next     = dsu_pkg::ST_MERGE;
            end
            dsu_pkg::ST_MERGE: begin
                cmd.do_merge = 1'b1;
                state_next   = dsu_pkg::ST_RES_RD;
            end
            dsu_pkg::ST_RES_RD: begin
                cmd.rd_result = 1'b1;
                state_next    = dsu_pkg::ST_RES_WAIT;
            end
            dsu_pkg::ST_RES_WAIT: begin
                cmd.rd_result = 1'b1;
                state_next    = dsu_pkg::ST_OUT;
            end
            dsu_pkg::ST_OUT: begin
                cmd.rd_result = 1'b1;
                if (!out_valid_reg || m_tready) begin
                    cmd.cap_result = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = dsu_pkg::ST_IDLE;
                end
            end
            default: state_next = dsu_pkg::ST_IDLE;
        endcase
    end

endmodule : dsu_ctrl

`default_nettype wire

>>> hw/rtl/disjoint_set_union_engine_core.sv
// ----------------------------------------------------------------------------
// disjoint_set_union_engine_core
// Union-find store with union by size and path compression.
// Channels: s_ carries one item per beat (operation, node_a, node_b); m_
// returns one result beat per item. cfg_ writes element_count, which clamps
// to 1..NODES and clears the store.
// A bad index is flagged in the check state that follows the input beat and
// is reported without a root search. For a valid item, the engine walks each
// link from node_a and node_b to its root and then rewrites it to point at
// the root, since the parent memory is single-port with registered read.
// The next input beat can be taken in the cycle after the result registers.
// Reset and every configuration write start a clearing pass over every node
// of the memories; s_tready and cfg_ready stay low meanwhile.
// A finished result waits in the output register while m_tready is low;
// the next item is accepted and processed, and stalls only at its own
// output step until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module disjoint_set_union_engine_core #(
    parameter int unsigned NODES = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [0] operation, [10:1] node_a, [20:11] node_b
    input  wire logic [23:0] s_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [9:0] root_a, [19:10] root_b, [20] already_joined, [21] merged,
    // [32:22] set_members, [64:33] set_edges, [75:65] group_total,
    // [76] bad_index
    output logic [79:0]      m_tdata
);

    dsu_pkg::dp_cmd_t cmd;
    dsu_pkg::dp_sts_t sts;

    logic [9:0]  root_a, root_b;
    logic        joined, merged, bad;
    logic [10:0] members, groups;
    logic [31:0] edges;

    dsu_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cmd(cmd), .sts(sts)
    );

    dsu_datapath #(.NODES(NODES)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .sts(sts),
        .cfg_value(cfg_data),
        .in_op(s_tdata[0]), .in_a(s_tdata[10:1]), .in_b(s_tdata[20:11]),
        .res_root_a(root_a), .res_root_b(root_b),
        .res_joined(joined), .res_merged(merged),
        .res_members(members), .res_edges(edges),
        .res_groups(groups), .res_bad(bad)
    );

    assign m_tdata = {3'b000, bad, groups, edges, members, merged, joined, root_b, root_a};

endmodule : disjoint_set_union_engine_core

`default_nettype wire

>>> hw/rtl/dsu_checker.sv
// ----------------------------------------------------------------------------
// dsu_checker
// Port-level checks of the engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dsu_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed under stall");

    a_no_cfg_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !cfg_ready)
        else $error("config accepted while an item is in flight");

    a_bad_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[76] |-> m_tdata[64:0] == '0)
        else $error("bad index beat carries data");

    a_members: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[76] |-> m_tdata[32:22] != '0)
        else $error("empty set reported");

endmodule : dsu_checker

bind disjoint_set_union_engine_core dsu_checker u_dsu_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the disjoint-set union engine core.
//
// A directed opening covers bad indices, ties, chains, queries and the count
// register at its extremes; random phases then unite and query nodes mostly
// inside small element counts so that sets grow deep. A local union-find
// predictor tracks roots, sizes, edge totals and group count; every result
// beat is compared field by field. Both channels stall at random, and one
// long receiver hold-off backs up the input channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int NODES  = 1024;
    localparam int LIMIT  = 3000000;
    localparam int IDX_W  = dsu_pkg::IDX_W;
    localparam int CNT_W  = dsu_pkg::CNT_W;
    localparam int EDGE_W = dsu_pkg::EDGE_W;

    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
    } item_t;

    // lowest field last, to line up with m_tdata
    typedef struct packed {
        logic              bad;
        logic [CNT_W-1:0]  groups;
        logic [EDGE_W-1:0] edges;
        logic [CNT_W-1:0]  members;
        logic              merged;
        logic              joined;
        logic [IDX_W-1:0]  root_b;
        logic [IDX_W-1:0]  root_a;
    } result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [23:0] s_tdata = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [10:0] cfg_data = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [79:0] m_tdata;

    disjoint_set_union_engine_core #(.NODES(NODES)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor state
    int unsigned       link [NODES];
    int unsigned       size_of [NODES];
    logic [EDGE_W-1:0] edges_of [NODES];
    int unsigned       group_cnt;
    int unsigned       node_limit;

    item_t   pending_items[$];
    result_t expected_results[$];
    int      errors = 0;
    int      cycles = 0;
    int      beats_out = 0;
    int      unites_sent = 0;
    int      bad_sent = 0;
    bit      hold_go = 0;
    bit      hold_off = 0;
    logic    s_tready_seen = 1'b0;
    bit      burst = 0;
    int      gap_left = 0;
    int      stall_left = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [EDGE_W-1:0] sat_sum(logic [EDGE_W-1:0] x,
                                                 logic [EDGE_W-1:0] y);
        logic [EDGE_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[EDGE_W] ? dsu_pkg::EDGE_MAX : s[EDGE_W-1:0];
    endfunction

    function automatic void clear_forest(int unsigned count);
        for (int unsigned i = 0; i < NODES; i++) begin
            link[i] = i;
            size_of[i] = 1;
            edges_of[i] = '0;
        end
        node_limit = (count < 1) ? 1 : ((count > NODES) ? NODES : count);
        group_cnt = node_limit;
    endfunction

    function automatic int unsigned find_root(int unsigned n);
        int unsigned r;
        int unsigned nxt;
        r = n;
        while (link[r] != r) r = link[r];
        while (n != r) begin
            nxt = link[n];
            link[n] = r;
            n = nxt;
        end
        return r;
    endfunction

    function automatic result_t predict_union(item_t it);
        result_t res;
        int unsigned ra;
        int unsigned rb;
        int unsigned win;
        int unsigned lose;
        res = '0;
        if (it.a >= node_limit || it.b >= node_limit) begin
            res.groups = CNT_W'(group_cnt);
            res.bad = 1'b1;
            return res;
        end
        ra = find_root(it.a);
        rb = find_root(it.b);
        res.joined = (ra == rb);
        if (it.op == dsu_pkg::OP_UNITE) begin
            edges_of[ra] = sat_sum(edges_of[ra], EDGE_W'(1));
            if (ra != rb) begin
                win = ra;
                lose = rb;
                if (size_of[ra] < size_of[rb]) begin
                    win = rb;
                    lose = ra;
                end
                size_of[win] += size_of[lose];
                edges_of[win] = sat_sum(edges_of[win], edges_of[lose]);
                link[lose] = win;
                if (group_cnt > 1) group_cnt--;
                res.merged = 1'b1;
                ra = win;
                rb = win;
            end
        end
        res.root_a = IDX_W'(ra);
        res.root_b = IDX_W'(rb);
        res.members = CNT_W'(size_of[ra]);
        res.edges = edges_of[ra];
        res.groups = CNT_W'(group_cnt);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("beat %0d: %s got %0d want %0d", beats_out, what, got, want);
    endtask

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready_seen) begin
                if (gap_left > 0 && !burst) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    s_tdata <= {3'b0, pending_items[0].b, pending_items[0].a,
                                pending_items[0].op};
                    s_tvalid <= 1'b1;
                    if (!burst && $urandom_range(0, 3) == 0) begin
                        gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                                 : $urandom_range(1, 3);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        s_tready_seen <= 1'b0;
        if (aresetn && s_tvalid && s_tready) begin
            s_tready_seen <= 1'b1;
            expected_results.push_back(predict_union(pending_items.pop_front()));
        end
    end

    // long receiver hold-off
    initial begin
        wait (hold_go);
        hold_off = 1'b1;
        repeat (2000) @(negedge aclk);
        hold_off = 1'b0;
    end

    // receiver readiness
    always @(negedge aclk) begin
        if (hold_off) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[76:0];
            beats_out++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected beat, root_a", got.root_a, 0);
            end else begin
                want = expected_results.pop_front();
                if (got.root_a !== want.root_a)
                    report_mismatch("root_a", got.root_a, want.root_a);
                if (got.root_b !== want.root_b)
                    report_mismatch("root_b", got.root_b, want.root_b);
                if (got.joined !== want.joined)
                    report_mismatch("already_joined", got.joined, want.joined);
                if (got.merged !== want.merged)
                    report_mismatch("merged", got.merged, want.merged);
                if (got.members !== want.members)
                    report_mismatch("set_members", got.members, want.members);
                if (got.edges !== want.edges)
                    report_mismatch("set_edges", got.edges, want.edges);
                if (got.groups !== want.groups)
                    report_mismatch("group_total", got.groups, want.groups);
                if (got.bad !== want.bad)
                    report_mismatch("bad_index", got.bad, want.bad);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("disjoint_set_union_engine_core: mismatch");
            $finish;
        end
    end

    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_count(logic [10:0] value);
        @(negedge aclk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        clear_forest(value);
    endtask

    function automatic void add_item(logic op, int unsigned a, int unsigned b);
        item_t it;
        it.op = op;
        it.a = IDX_W'(a);
        it.b = IDX_W'(b);
        if (op == dsu_pkg::OP_UNITE) unites_sent++;
        if (a >= node_limit || b >= node_limit) bad_sent++;
        pending_items.push_back(it);
    endfunction

    // node pick: mostly in range, occasionally past the limit or anywhere
    function automatic int unsigned pick_node();
        int unsigned r;
        r = $urandom_range(0, 31);
        if (r == 0) return $urandom_range(0, NODES - 1);
        if (r == 1 && node_limit < NODES) return $urandom_range(node_limit, NODES - 1);
        return $urandom_range(0, node_limit - 1);
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            add_item($urandom_range(0, 2) != 0 ? dsu_pkg::OP_UNITE : dsu_pkg::OP_QUERY,
                     pick_node(), pick_node());
        drain();
    endtask

    initial begin
        clear_forest(NODES);
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed
        add_item(dsu_pkg::OP_QUERY, 0, 1023);
        add_item(dsu_pkg::OP_UNITE, 1023, 0);
        add_item(dsu_pkg::OP_UNITE, 0, 1023);
        add_item(dsu_pkg::OP_UNITE, 5, 6);
        add_item(dsu_pkg::OP_UNITE, 6, 0);
        add_item(dsu_pkg::OP_UNITE, 5, 5);
        add_item(dsu_pkg::OP_QUERY, 6, 1023);
        add_item(dsu_pkg::OP_QUERY, 682, 341);
        add_item(dsu_pkg::OP_UNITE, 341, 682);
        add_item(dsu_pkg::OP_UNITE, 7, 341);
        drain();
        write_count(11'd0);
        add_item(dsu_pkg::OP_UNITE, 0, 0);
        add_item(dsu_pkg::OP_QUERY, 0, 1);
        add_item(dsu_pkg::OP_UNITE, 1023, 0);
        drain();
        write_count(11'h7FF);
        add_item(dsu_pkg::OP_UNITE, 1023, 1022);
        add_item(dsu_pkg::OP_QUERY, 1022, 1023);
        drain();
        write_count(11'd4);
        add_item(dsu_pkg::OP_UNITE, 0, 1);
        add_item(dsu_pkg::OP_UNITE, 2, 3);
        add_item(dsu_pkg::OP_UNITE, 3, 1);
        add_item(dsu_pkg::OP_QUERY, 3, 4);
        add_item(dsu_pkg::OP_UNITE, 0, 3);
        drain();

        // long receiver hold-off while items queue up
        write_count(11'd32);
        hold_go = 1'b1;
        for (int i = 0; i < 40; i++) add_item(dsu_pkg::OP_UNITE, pick_node(), pick_node());
        drain();

        write_count(11'd16);
        random_phase(300);
        write_count(11'd200);
        burst = 1;
        random_phase(300);
        burst = 0;
        write_count(11'd2);
        random_phase(100);
        write_count(11'd1024);
        random_phase(250);
        write_count(11'd1);
        random_phase(50);
        write_count(11'd64);
        random_phase(250);

        $display("covered %0d result beats, %0d unites, %0d out-of-range items",
                 beats_out, unites_sent, bad_sent);
        $display("element counts from 1 to 1024, long output stall included");
        if (errors == 0) begin
            $display("disjoint_set_union_engine_core: match");
        end else begin
            $display("disjoint_set_union_engine_core: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
